### rtl/info_frame_byte_stuffing_framer_macros.svh
// Assertion macros for the information frame byte-stuffing framer.
// Included by the modules that assert; expects clk and rst in scope.
`ifndef INFO_FRAME_BYTE_STUFFING_FRAMER_MACROS_SVH
`define INFO_FRAME_BYTE_STUFFING_FRAMER_MACROS_SVH

// condition that must hold at every edge out of reset
`define IFBSF_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent checked in the same cycle as the antecedent
`define IFBSF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define IFBSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ifbsf_pkg.sv
// Shared types and constants of the information frame byte-stuffing framer.
// No dependencies; compile first.
package ifbsf_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned MAX_RESULTS = 9;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int unsigned CTRL_SHIFT  = 6;
  localparam int unsigned NUM_REGS    = 4;
  localparam int unsigned PADDR_W     = $clog2(NUM_REGS) + 2;
  localparam int unsigned PDATA_W     = 32;

  localparam logic [BYTE_W-1:0] FLAG_RESET    = 8'h7E;
  localparam logic [BYTE_W-1:0] ESCAPE_RESET  = 8'h7D;
  localparam logic [BYTE_W-1:0] MASK_RESET    = 8'h20;
  localparam logic [BYTE_W-1:0] ADDRESS_RESET = 8'h03;

  typedef enum logic [$clog2(NUM_REGS)-1:0] {
    REG_FLAG    = 2'd0,
    REG_ESCAPE  = 2'd1,
    REG_MASK    = 2'd2,
    REG_ADDRESS = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0] flag_value;
    logic [BYTE_W-1:0] escape_value;
    logic [BYTE_W-1:0] stuff_mask;
    logic [BYTE_W-1:0] address_value;
  } cfg_t;

  // One expanded item: line bytes in send order (slot 0 first).
  typedef struct packed {
    logic [MAX_RESULTS-1:0][BYTE_W-1:0] bytes;
    logic [CNT_W-1:0]                   count;
    logic                               closes;
    logic                               inside_next;
    logic [BYTE_W-1:0]                  parity_next;
  } run_t;

endpackage

### rtl/ifbsf_if.sv
// Channel interfaces of the framer: payload bytes in, line bytes out.
// Depends on ifbsf_pkg.
interface ifbsf_in_if;
  import ifbsf_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] payload_byte;
  logic              sequence_bit;
  logic              last_payload;

  modport source (output valid, payload_byte, sequence_bit, last_payload, input ready);
  modport sink   (input valid, payload_byte, sequence_bit, last_payload, output ready);
endinterface

interface ifbsf_out_if;
  import ifbsf_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] line_byte;
  logic              run_end;
  logic              frame_end;

  modport source (output valid, line_byte, run_end, frame_end, input ready);
  modport sink   (input valid, line_byte, run_end, frame_end, output ready);
endinterface

### rtl/ifbsf_expand.sv
// Expands one registered payload byte into its run of line bytes.
// Depends on ifbsf_pkg.
module ifbsf_expand (
  input  ifbsf_pkg::cfg_t                    cfg,
  input  logic                               inside_frame,
  input  logic [ifbsf_pkg::BYTE_W-1:0]       payload_parity,
  input  logic [ifbsf_pkg::BYTE_W-1:0]       payload_byte,
  input  logic                               sequence_bit,
  input  logic                               last_payload,
  output ifbsf_pkg::run_t                    run
);
  import ifbsf_pkg::*;

  logic [BYTE_W-1:0] ctrl;
  logic [BYTE_W-1:0] bcc2;
  logic              data_esc;
  logic              bcc_esc;
  logic [CNT_W-1:0]  pos;

  assign ctrl     = BYTE_W'(sequence_bit) << CTRL_SHIFT;
  assign bcc2     = (inside_frame ? payload_parity : '0) ^ payload_byte;
  assign data_esc = (payload_byte == cfg.escape_value) || (payload_byte == cfg.flag_value);
  assign bcc_esc  = (bcc2 == cfg.escape_value) || (bcc2 == cfg.flag_value);

  always_comb begin
    run.bytes = '0;
    pos       = '0;
    // unstuffed header on the first byte of a frame
    if (!inside_frame) begin
      run.bytes[0] = cfg.flag_value;
      run.bytes[1] = cfg.address_value;
      run.bytes[2] = ctrl;
      run.bytes[3] = cfg.address_value ^ ctrl;
      pos          = CNT_W'(4);
    end
    if (data_esc) begin
      run.bytes[pos]              = cfg.escape_value;
      run.bytes[pos + CNT_W'(1)]  = payload_byte ^ cfg.stuff_mask;
      pos                         = pos + CNT_W'(2);
    end else begin
      run.bytes[pos] = payload_byte;
      pos            = pos + CNT_W'(1);
    end
    if (last_payload) begin
      if (bcc_esc) begin
        run.bytes[pos]             = cfg.escape_value;
        run.bytes[pos + CNT_W'(1)] = bcc2 ^ cfg.stuff_mask;
        pos                        = pos + CNT_W'(2);
      end else begin
        run.bytes[pos] = bcc2;
        pos            = pos + CNT_W'(1);
      end
      run.bytes[pos] = cfg.flag_value;
      pos            = pos + CNT_W'(1);
    end
    run.count       = pos;
    run.closes      = last_payload;
    run.inside_next = !last_payload;
    run.parity_next = last_payload ? '0 : bcc2;
  end

endmodule

### rtl/info_frame_byte_stuffing_framer.sv
// Top level of the information frame byte-stuffing framer.
// Depends on ifbsf_pkg, ifbsf_if, ifbsf_expand and the macros header.
//
//   channel   kind      direction  beat
//   feed      valid/rdy in         payload_byte, sequence_bit, last_payload
//   line      valid/rdy out        line_byte, run_end, frame_end
//   apb       psel/pen  in/out     flag, escape, mask, address registers
//
// Each payload beat yields a run of line bytes: 1 for an interior unstuffed
// byte, up to 9 for a one-byte frame with header, both stuffed and closing
// flag. The single-byte line port sends a run one byte per line beat.
// One item waits in the input register while the previous run drains, so
// a new beat enters in the cycle the last byte of a run leaves.
// Reset (rst, synchronous) empties both stages, clears frame state and
// restores register defaults. A line stall holds the head byte in place.
module info_frame_byte_stuffing_framer (
  input  logic                             clk,
  input  logic                             rst,
  ifbsf_in_if.sink                         feed,
  ifbsf_out_if.source                      line,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ifbsf_pkg::PADDR_W-1:0]    paddr,
  input  logic [ifbsf_pkg::PDATA_W-1:0]    pwdata,
  output logic [ifbsf_pkg::PDATA_W-1:0]    prdata,
  output logic                             pready
);
  import ifbsf_pkg::*;

  `include "info_frame_byte_stuffing_framer_macros.svh"

  // configuration registers
  cfg_t     cfg;
  reg_idx_t reg_sel;

  // input register
  logic              in_vld;
  logic [BYTE_W-1:0] in_byte;
  logic              in_seq;
  logic              in_last;

  // frame state, advanced when an item moves into the emitter
  logic              framing;
  logic [BYTE_W-1:0] parity;

  // emitter: slot 0 is the head byte on the line
  logic [MAX_RESULTS-1:0][BYTE_W-1:0] slots;
  logic [CNT_W-1:0]                   count;
  logic                               closes;

  run_t run;
  logic take;
  logic line_beat;

  assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign pready  = 1'b1;

  // --- APB register file --------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flag_value    <= FLAG_RESET;
      cfg.escape_value  <= ESCAPE_RESET;
      cfg.stuff_mask    <= MASK_RESET;
      cfg.address_value <= ADDRESS_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_FLAG:    cfg.flag_value    <= pwdata[BYTE_W-1:0];
        REG_ESCAPE:  cfg.escape_value  <= pwdata[BYTE_W-1:0];
        REG_MASK:    cfg.stuff_mask    <= pwdata[BYTE_W-1:0];
        REG_ADDRESS: cfg.address_value <= pwdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FLAG:    prdata = PDATA_W'(cfg.flag_value);
      REG_ESCAPE:  prdata = PDATA_W'(cfg.escape_value);
      REG_MASK:    prdata = PDATA_W'(cfg.stuff_mask);
      REG_ADDRESS: prdata = PDATA_W'(cfg.address_value);
      default:     prdata = '0;
    endcase
  end

  // --- handshakes ---------------------------------------------------------
  assign line_beat  = line.valid && line.ready;
  // load the emitter when it is empty or sends its final byte this cycle
  assign take       = in_vld && ((count == '0) || ((count == CNT_W'(1)) && line.ready));
  assign feed.ready = !in_vld || take;

  // --- input register -----------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (feed.ready) begin
      in_vld <= feed.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (feed.valid && feed.ready) begin
      in_byte <= feed.payload_byte;
      in_seq  <= feed.sequence_bit;
      in_last <= feed.last_payload;
    end
  end

  // --- expansion: header, stuffing, block check, closing flag -------------
  ifbsf_expand u_expand (
    .cfg            (cfg),
    .inside_frame   (framing),
    .payload_parity (parity),
    .payload_byte   (in_byte),
    .sequence_bit   (in_seq),
    .last_payload   (in_last),
    .run            (run)
  );

  // advance frame state as the item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      framing <= 1'b0;
      parity  <= '0;
    end else if (take) begin
      framing <= run.inside_next;
      parity  <= run.parity_next;
    end
  end

  // --- emitter: shift one byte out per line beat --------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (take) begin
      count <= run.count;
    end else if (line_beat) begin
      count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      slots  <= run.bytes;
      closes <= run.closes;
    end else if (line_beat) begin
      slots <= {BYTE_W'(0), slots[MAX_RESULTS-1:1]};
    end
  end

  assign line.valid     = (count != '0);
  assign line.line_byte = slots[0];
  assign line.run_end   = (count == CNT_W'(1));
  assign line.frame_end = closes && (count == CNT_W'(1));

  // --- assertions ---------------------------------------------------------
  `IFBSF_ASSERT_NOW(a_count_range, count <= CNT_W'(MAX_RESULTS), "emitter count overflow")
  `IFBSF_ASSERT_IMP(a_run_nonempty, take, run.count != '0, "empty run loaded")
  `IFBSF_ASSERT_IMP(a_close_is_run_end, line.valid && line.frame_end, line.run_end,
                    "closing flag not at end of run")
  `IFBSF_ASSERT_NEXT(a_load_count, take, count == $past(run.count), "emitter load lost")
  `IFBSF_ASSERT_NEXT(a_close_clears, take && run.closes, !framing && (parity == '0),
                     "frame state not cleared on close")

endmodule
